[sv/decimal_to_radix_p_string_defines.svh]
// Assertion macros shared by the radix string converter RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef DECIMAL_TO_RADIX_P_STRING_DEFINES_SVH
`define DECIMAL_TO_RADIX_P_STRING_DEFINES_SVH
`ifndef SYNTHESIS
`define D2RP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("d2rp assertion failed");
`define D2RP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("d2rp assertion failed");
`else
`define D2RP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons)
`define D2RP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

[sv/d2rp_pkg.sv]
// Package for the radix string converter: widths, register indexes, payload types,
// controller states, command and status structs and the digit-to-ASCII function.
// Has no dependencies.
`default_nettype none
package d2rp_pkg;

  localparam int INT_BITS            = 31;
  localparam int FRAC_BITS           = 32;
  localparam int DEF_MAX_FRAC_DIGITS = 31;
  localparam int RADIX_W             = 5;
  localparam int LIMIT_W             = 5;
  localparam int DIGIT_W             = 4;
  localparam int CHAR_W              = 8;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 5;

  localparam int DIV_STEPS  = 8;
  localparam int DIV_W      = ((INT_BITS + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int DIV_CHUNKS = DIV_W / DIV_STEPS;
  localparam int CHUNK_W    = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;
  localparam int INT_IDX_W  = $clog2(INT_BITS);
  localparam int INT_CNT_W  = $clog2(INT_BITS + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd0;
  localparam logic [LIMIT_W-1:0] DEFAULT_FRAC_DIGITS = 5'd5;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_LIMIT = 2'd1;

  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

  typedef struct packed {
    logic                 is_negative;
    logic [INT_BITS-1:0]  integer_magnitude;
    logic [FRAC_BITS-1:0] fraction_bits;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FRAC,
    ST_EMIT_SIGN,
    ST_EMIT_INT,
    ST_EMIT_DOT,
    ST_EMIT_FRAC
  } state_t;

  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_INT,
    SEL_DOT,
    SEL_FRAC
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      frac_step;
    logic      frac_rewind;
    logic      emit;
    char_sel_t sel;
    logic      last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic quo_done;
    logic frac_go;
    logic show_sign;
    logic has_dot;
    logic int_one;
    logic keep_zero;
    logic frac_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DIGIT_TEN) begin
      ch = CHAR_ZERO + {4'd0, d};
    end else begin
      ch = CHAR_UPPER_A + {4'd0, d - DIGIT_TEN};
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

[sv/decimal_to_radix_p_string.sv]
// Top level of the radix string converter: joins controller and datapath and
// drives the configuration handshake. Depends on d2rp_pkg and both submodules.
//
// A request on the input channel carries a sign flag, a 31-bit integer magnitude
// and a Q0.32 fraction. The block answers with the number's text in the configured
// radix, one ASCII character per output request, is_last set on the final one.
// The configuration channel writes register 0 (radix) and register 1 (fraction
// digit limit); cfg_ready is always high and writes are meant for idle periods.
// Integer digits come from a shared divider that takes 8 dividend bits per cycle,
// so each integer digit takes one pass over the whole dividend; each fraction digit
// takes one multiply by the radix; each character passes through the output register.
// One number is in work at a time; in_stall is low only while the controller is idle,
// and the next number is taken while the last character still waits in the output
// register. A stalled output holds its character and pauses the character sequence.
// Reset returns the radix to 10 and the digit limit to 0 and empties the output.
`default_nettype none
module decimal_to_radix_p_string
  import d2rp_pkg::*;
#(
  parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  d2rp_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  d2rp_datapath #(
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[sv/d2rp_datapath.sv]
// Datapath of the radix string converter: configuration registers, the digit-serial
// divider, the fraction multiplier, both digit buffers and the output register.
// Depends on d2rp_pkg.
`default_nettype none
module d2rp_datapath
  import d2rp_pkg::*;
#(
  parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire in_item_t              in_data,
  input  wire ctrl_cmd_t             cmd,
  output dp_status_t                 status,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data
);

  localparam int FIDX_W = $clog2(MAX_FRAC_DIGITS);
  localparam int FCNT_W = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int PROD_W = FRAC_BITS + RADIX_W;
  localparam logic [LIMIT_W-1:0] FRAC_CAP = LIMIT_W'(MAX_FRAC_DIGITS);
  localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(DIV_CHUNKS - 1);

  logic [RADIX_W-1:0]   radix_r;
  logic [LIMIT_W-1:0]   limit_r;
  logic [RADIX_W-1:0]   p_eff;

  logic                 sign_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIGIT_W-1:0]   rem_r;
  logic [CHUNK_W-1:0]   chunk_r;
  logic [INT_CNT_W-1:0] n_int_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [FCNT_W-1:0]    count_r;
  logic [FCNT_W-1:0]    n_frac_r;
  logic [FCNT_W-1:0]    keep_r;

  logic [DIGIT_W-1:0]   int_buf [INT_BITS];
  logic [DIGIT_W-1:0]   frac_buf [MAX_FRAC_DIGITS];

  logic [DIV_W-1:0]     quo_v;
  logic [DIGIT_W-1:0]   rem_v;
  logic [DIGIT_W:0]     trial;
  logic [LIMIT_W-1:0]   limit_eff;
  logic [FCNT_W-1:0]    count_load;
  logic [PROD_W-1:0]    prod;
  logic [DIGIT_W-1:0]   frac_digit;
  logic [INT_CNT_W-1:0] int_top;
  logic [FCNT_W-1:0]    n_frac_inc;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_RADIX) begin
        radix_r <= cfg_data;
      end else if (cfg_index == REG_FRAC_LIMIT) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_comb begin
    if (radix_r < RADIX_MIN) begin
      p_eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      p_eff = RADIX_MAX;
    end else begin
      p_eff = radix_r;
    end
  end

  // Restoring division by the radix, eight dividend bits per cycle.
  always_comb begin
    rem_v = rem_r;
    quo_v = quo_r;
    trial = '0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      trial = {rem_v, quo_v[DIV_W-1]};
      quo_v = {quo_v[DIV_W-2:0], 1'b0};
      if (trial >= p_eff) begin
        rem_v    = DIGIT_W'(trial - p_eff);
        quo_v[0] = 1'b1;
      end else begin
        rem_v = trial[DIGIT_W-1:0];
      end
    end
  end

  always_comb begin
    if (limit_r == '0 && in_data.fraction_bits != '0) begin
      limit_eff = DEFAULT_FRAC_DIGITS;
    end else begin
      limit_eff = limit_r;
    end
    if (limit_eff > FRAC_CAP) begin
      count_load = FCNT_W'(MAX_FRAC_DIGITS);
    end else begin
      count_load = limit_eff[FCNT_W-1:0];
    end
  end

  assign prod       = PROD_W'(frac_r) * PROD_W'(p_eff);
  assign frac_digit = prod[FRAC_BITS +: DIGIT_W];
  assign int_top    = n_int_r - 1'b1;
  assign n_frac_inc = n_frac_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sign_r  <= in_data.is_negative &&
                 (in_data.integer_magnitude != '0 || in_data.fraction_bits != '0);
      quo_r   <= DIV_W'(in_data.integer_magnitude);
      rem_r   <= '0;
      chunk_r <= '0;
      n_int_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= quo_v;
      if (chunk_r == CHUNK_LAST) begin
        rem_r   <= '0;
        chunk_r <= '0;
        n_int_r <= n_int_r + 1'b1;
      end else begin
        rem_r   <= rem_v;
        chunk_r <= chunk_r + 1'b1;
      end
    end else if (cmd.emit && cmd.sel == SEL_INT) begin
      n_int_r <= int_top;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && chunk_r == CHUNK_LAST) begin
      int_buf[n_int_r[INT_IDX_W-1:0]] <= rem_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frac_r   <= in_data.fraction_bits;
      count_r  <= count_load;
      n_frac_r <= '0;
      keep_r   <= '0;
    end else if (cmd.frac_step) begin
      frac_r   <= prod[FRAC_BITS-1:0];
      n_frac_r <= n_frac_inc;
      if (frac_digit != '0) begin
        keep_r <= n_frac_inc;
      end
    end else if (cmd.frac_rewind) begin
      n_frac_r <= '0;
    end else if (cmd.emit && cmd.sel == SEL_FRAC) begin
      n_frac_r <= n_frac_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frac_step) begin
      frac_buf[n_frac_r[FIDX_W-1:0]] <= frac_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.sel)
        SEL_MINUS: out_char_r <= CHAR_MINUS;
        SEL_INT:   out_char_r <= glyph(int_buf[int_top[INT_IDX_W-1:0]]);
        SEL_DOT:   out_char_r <= CHAR_DOT;
        SEL_FRAC:  out_char_r <= glyph(frac_buf[n_frac_r[FIDX_W-1:0]]);
        default:   out_char_r <= CHAR_DOT;
      endcase
      out_last_r <= cmd.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.char_code = out_char_r;
  assign out_data.is_last   = out_last_r;

  assign status.quo_done  = (chunk_r == CHUNK_LAST) && (quo_v == '0);
  assign status.frac_go   = (frac_r != '0) && (n_frac_r < count_r);
  assign status.show_sign = sign_r;
  assign status.has_dot   = (count_r != '0);
  assign status.int_one   = (n_int_r == INT_CNT_W'(1));
  assign status.keep_zero = (keep_r == '0);
  assign status.frac_last = (n_frac_inc == keep_r);
  assign status.out_free  = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

[sv/d2rp_controller.sv]
// Controller of the radix string converter: sequences division, fraction digits
// and character output. Depends on d2rp_pkg and the assertion macro header.
`default_nettype none
`include "decimal_to_radix_p_string_defines.svh"
module d2rp_controller
  import d2rp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (status.quo_done) state_nxt = ST_FRAC;
      end
      ST_FRAC: begin
        if (!status.frac_go) state_nxt = status.show_sign ? ST_EMIT_SIGN : ST_EMIT_INT;
      end
      ST_EMIT_SIGN: begin
        if (status.out_free) state_nxt = ST_EMIT_INT;
      end
      ST_EMIT_INT: begin
        if (status.out_free && status.int_one) begin
          state_nxt = status.has_dot ? ST_EMIT_DOT : ST_IDLE;
        end
      end
      ST_EMIT_DOT: begin
        if (status.out_free) state_nxt = status.keep_zero ? ST_IDLE : ST_EMIT_FRAC;
      end
      ST_EMIT_FRAC: begin
        if (status.out_free && status.frac_last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_FRAC: begin
        cmd.frac_step   = status.frac_go;
        cmd.frac_rewind = !status.frac_go;
      end
      ST_EMIT_SIGN: begin
        cmd.emit = status.out_free;
        cmd.sel  = SEL_MINUS;
      end
      ST_EMIT_INT: begin
        cmd.emit = status.out_free;
        cmd.sel  = SEL_INT;
        cmd.last = status.int_one && !status.has_dot;
      end
      ST_EMIT_DOT: begin
        cmd.emit = status.out_free;
        cmd.sel  = SEL_DOT;
        cmd.last = status.keep_zero;
      end
      ST_EMIT_FRAC: begin
        cmd.emit = status.out_free;
        cmd.sel  = SEL_FRAC;
        cmd.last = status.frac_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `D2RP_ASSERT_NEXT(a_last_char_ends, clk, rst_n, cmd.emit && cmd.last, state_r == ST_IDLE)
  `D2RP_ASSERT_NEXT(a_load_starts_div, clk, rst_n, cmd.load, state_r == ST_DIV)
  `D2RP_ASSERT_NOW(a_frac_emit_nonempty, clk, rst_n, state_r == ST_EMIT_FRAC, !status.keep_zero)

endmodule
`default_nettype wire

[tb/decimal_to_radix_p_string_tb.sv]
// Self-checking testbench for decimal_to_radix_p_string: numbers in, radix text out.
// Predicts every character from the fields and the register settings and compares.
// Depends on d2rp_pkg and the decimal_to_radix_p_string RTL only.
module decimal_to_radix_p_string_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import d2rp_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int TEXT_DIGITS = 31;
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_B = 2'd3;
  localparam logic [INT_BITS-1:0] MAG_MAX = '1;
  localparam logic [FRAC_BITS-1:0] FRAC_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
  logic [LIMIT_W-1:0] limit_setting = LIMIT_RESET;
  out_item_t expected_chars[$];
  int mismatches = 0;
  int numbers_sent = 0;
  int chars_checked = 0;
  int settings_used = 1;
  int cycle_count = 0;
  bit input_gaps_on = 1'b1;
  bit output_stalls_on = 1'b1;
  int hold_request = 0;
  int hold_left = 0;
  int stall_run = 0;

  decimal_to_radix_p_string dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("decimal_to_radix_p_string test failed");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    string symbols;
    symbols = "0123456789ABCDEF";
    return symbols[d];
  endfunction

  function automatic void spell_number(input in_item_t item);
    out_item_t text[$];
    out_item_t ch;
    logic [3:0] int_digits [0:TEXT_DIGITS-1];
    logic [3:0] frac_digits [0:TEXT_DIGITS-1];
    logic [31:0] base;
    logic [31:0] mag;
    logic [31:0] frac;
    logic [35:0] prod;
    int count;
    int n_int;
    int n_frac;
    base = 32'(radix_setting);
    if (base < 2) base = 2;
    if (base > 16) base = 16;
    count = int'(limit_setting);
    mag = 32'(item.integer_magnitude);
    frac = item.fraction_bits;
    if (count == 0 && frac != 0) count = 5;
    if (count > TEXT_DIGITS) count = TEXT_DIGITS;
    ch.is_last = 1'b0;
    if (item.is_negative && (mag != 0 || frac != 0)) begin
      ch.char_code = CHAR_MINUS;
      text = {text, ch};
    end
    n_int = 0;
    if (mag == 0) begin
      int_digits[0] = 4'd0;
      n_int = 1;
    end
    while (mag != 0 && n_int < TEXT_DIGITS) begin
      int_digits[n_int] = 4'(mag % base);
      mag = mag / base;
      n_int++;
    end
    for (int i = n_int - 1; i >= 0; i--) begin
      ch.char_code = digit_char(int_digits[i]);
      text = {text, ch};
    end
    if (count > 0) begin
      ch.char_code = CHAR_DOT;
      text = {text, ch};
      n_frac = 0;
      while (frac != 0 && n_frac < count) begin
        prod = {4'd0, frac} * base;
        frac_digits[n_frac] = prod[35:32];
        frac = prod[31:0];
        n_frac++;
      end
      while (n_frac > 0 && frac_digits[n_frac-1] == 4'd0) n_frac--;
      for (int i = 0; i < n_frac; i++) begin
        ch.char_code = digit_char(frac_digits[i]);
        text = {text, ch};
      end
    end
    text[text.size()-1].is_last = 1'b1;
    expected_chars = {expected_chars, text};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got %0h, expected %0h (cycle %0d, %0d numbers sent)",
             what, got, want, cycle_count, numbers_sent);
  endtask

  always @(posedge clk) begin : check_text
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("character with none expected", 32'(out_data.char_code), 0);
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_data.char_code !== want.char_code) begin
          report_mismatch("char_code", 32'(out_data.char_code), 32'(want.char_code));
        end
        if (out_data.is_last !== want.is_last) begin
          report_mismatch("is_last", 32'(out_data.is_last), 32'(want.is_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if (output_stalls_on && $urandom_range(0, 99) < 20) begin
      stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (!input_gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_number(input in_item_t item);
    int gap;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    spell_number(item);
    numbers_sent++;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic neg, input logic [INT_BITS-1:0] mag,
                             input logic [FRAC_BITS-1:0] frac);
    in_item_t item;
    item.is_negative = neg;
    item.integer_magnitude = mag;
    item.fraction_bits = frac;
    send_number(item);
  endtask

  task automatic wait_for_text(input int settle);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RADIX: radix_setting = val;
      REG_FRAC_LIMIT: limit_setting = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [RADIX_W-1:0] base, input logic [LIMIT_W-1:0] limit);
    in_valid <= 1'b0;
    wait_for_text(SETTLE_CYCLES);
    write_reg(REG_RADIX, base);
    write_reg(REG_FRAC_LIMIT, limit);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic in_item_t pick_number();
    in_item_t item;
    item.is_negative = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: item.integer_magnitude = '0;
      1: item.integer_magnitude = INT_BITS'($urandom_range(0, 99));
      2: item.integer_magnitude = MAG_MAX;
      default: item.integer_magnitude = INT_BITS'($urandom >> $urandom_range(0, 30));
    endcase
    case ($urandom_range(0, 5))
      0: item.fraction_bits = '0;
      1: item.fraction_bits = $urandom & 32'hFF00_0000;
      2: item.fraction_bits = FRAC_MAX;
      default: item.fraction_bits = $urandom;
    endcase
    return item;
  endfunction

  task automatic test_reset_settings();
    send_fields(1'b0, '0, '0);
    send_fields(1'b1, '0, '0);
    send_fields(1'b1, '0, 32'h8000_0000);
    send_fields(1'b0, 31'd123, 32'h4000_0000);
    send_fields(1'b1, MAG_MAX, FRAC_MAX);
  endtask

  task automatic test_extreme_fields();
    configure(5'd2, 5'd31);
    send_fields(1'b1, MAG_MAX, FRAC_MAX);
    send_fields(1'b0, '0, 32'h0000_0001);
    configure(5'd16, 5'd31);
    send_fields(1'b0, MAG_MAX, FRAC_MAX);
    send_fields(1'b1, 31'h2BAD_F00D, 32'hABCD_EF01);
    configure(5'd3, 5'd31);
    send_fields(1'b0, 31'd1, 32'h5555_5555);
  endtask

  task automatic test_saturated_radix();
    configure(5'd0, 5'd3);
    send_fields(1'b0, 31'd5, 32'hC000_0000);
    configure(5'd1, 5'd0);
    send_fields(1'b1, 31'd6, '0);
    configure(5'd17, 5'd4);
    send_fields(1'b0, 31'd255, '0);
    configure(5'd31, 5'd7);
    send_fields(1'b1, 31'd4095, 32'h1234_5678);
  endtask

  task automatic test_dot_only_and_trim();
    configure(5'd10, 5'd1);
    send_fields(1'b0, 31'd9, 32'h0CCC_CCCD);
    send_fields(1'b1, '0, '0);
    send_fields(1'b0, 31'd7, '0);
  endtask

  task automatic test_spare_indexes();
    in_valid <= 1'b0;
    wait_for_text(SETTLE_CYCLES);
    write_reg(SPARE_INDEX_A, 5'd3);
    write_reg(SPARE_INDEX_B, 5'd0);
    cfg_valid <= 1'b0;
    send_fields(1'b0, 31'd100, 32'h8000_0000);
  endtask

  task automatic test_random_numbers();
    logic [RADIX_W-1:0] base;
    logic [LIMIT_W-1:0] limit;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        base = 5'd2;
        limit = 5'd31;
      end else if (phase == 1) begin
        base = 5'd16;
        limit = 5'd0;
      end else begin
        base = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(2, 16));
        limit = 5'($urandom_range(0, 31));
      end
      configure(base, limit);
      input_gaps_on = (phase != 3);
      output_stalls_on = (phase != 3);
      for (int i = 0; i < 30; i++) send_number(pick_number());
    end
    input_gaps_on = 1'b1;
    output_stalls_on = 1'b1;
  endtask

  task automatic test_receiver_hold();
    configure(5'd2, 5'd31);
    input_gaps_on = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 6; i++) send_fields(1'($urandom_range(0, 1)), MAG_MAX, $urandom);
    input_gaps_on = 1'b1;
    in_valid <= 1'b0;
    wait_for_text(SETTLE_CYCLES);
    for (int i = 0; i < 4; i++) send_number(pick_number());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_settings();
    test_extreme_fields();
    test_saturated_radix();
    test_dot_only_and_trim();
    test_spare_indexes();
    test_receiver_hold();
    test_random_numbers();
    in_valid <= 1'b0;
    wait_for_text(END_CYCLES);
    $display("Converted %0d numbers over %0d register settings, saturated radix included.",
             numbers_sent, settings_used);
    $display("Checked %0d characters under random gaps, stalls and one long hold.",
             chars_checked);
    if (mismatches == 0) begin
      $display("decimal_to_radix_p_string test passed");
    end else begin
      $display("decimal_to_radix_p_string test failed");
    end
    $finish;
  end
endmodule

[decimal_to_radix_p_string.f]
+incdir+sv
sv/d2rp_pkg.sv
sv/d2rp_datapath.sv
sv/d2rp_controller.sv
sv/decimal_to_radix_p_string.sv
tb/decimal_to_radix_p_string_tb.sv
